// File: design/b64c_pkg.sv
// Shared types, constants and character functions of the Base64 codec.
// Used by the step logic and the top level.
package b64c_pkg;

  localparam int unsigned MaxRes   = 4;
  localparam int unsigned ResIdxW  = $clog2(MaxRes);
  localparam int unsigned ResCntW  = $clog2(MaxRes + 1);

  localparam logic [7:0] PadChar = 8'h3D;  // '='

  localparam logic [0:0] ModeEncode = 1'b0;
  localparam logic [0:0] ModeDecode = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_error;
  } res_t;

  // Stream state between items of one message.
  typedef struct packed {
    logic [6:0] bit_buffer;
    logic [2:0] bit_count;
    logic [1:0] char_phase;
    logic       error_seen;
  } st_t;

  typedef enum logic [1:0] {
    DigValue = 2'd0,
    DigPad   = 2'd1,
    DigBad   = 2'd2
  } dig_kind_e;

  typedef struct packed {
    dig_kind_e  kind;
    logic [5:0] value;
  } dig_t;

  // Map a 6-bit value to its character of the standard alphabet.
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  // Classify a 7-bit character and give its digit value when it is one.
  function automatic dig_t dec_char(input logic [6:0] c);
    dig_t d;
    d.kind  = DigBad;
    d.value = 6'd0;
    if (c >= 7'h41 && c <= 7'h5A) begin
      d.kind  = DigValue;
      d.value = 6'(c - 7'h41);
    end else if (c >= 7'h61 && c <= 7'h7A) begin
      d.kind  = DigValue;
      d.value = 6'(c - 7'h61 + 7'd26);
    end else if (c >= 7'h30 && c <= 7'h39) begin
      d.kind  = DigValue;
      d.value = 6'(c - 7'h30 + 7'd52);
    end else if (c == 7'h2B) begin
      d.kind  = DigValue;
      d.value = 6'd62;
    end else if (c == 7'h2F) begin
      d.kind  = DigValue;
      d.value = 6'd63;
    end else if (c == 7'h3D) begin
      d.kind  = DigPad;
    end
    return d;
  endfunction

endpackage

// File: design/b64c_if.sv
// Valid/ready channel interfaces of the Base64 codec: input words, result
// words and the mode register write channel.

interface b64c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64c_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_error;
  logic       run_last;

  modport source (output valid, output out_byte, output is_error, output run_last,
                  input ready);
  modport sink   (input valid, input out_byte, input is_error, input run_last,
                  output ready);
endinterface

interface b64c_cfg_if;
  logic valid;
  logic ready;
  logic mode;

  modport source (output valid, output mode, input ready);
  modport sink   (input valid, input mode, output ready);
endinterface

// File: design/b64c_step.sv
// Combinational step of the codec: one word and the stream state in, up to
// four result words and the next state out. Depends on b64c_pkg.
module b64c_step (
  input  logic                            mode_i,
  input  b64c_pkg::item_t                 item_i,
  input  b64c_pkg::st_t                   st_i,
  output b64c_pkg::res_t [b64c_pkg::MaxRes-1:0] res_o,
  output logic [b64c_pkg::ResCntW-1:0]    cnt_o,
  output b64c_pkg::st_t                   st_o
);

  // Encode side.
  logic [5:0]  c0, c1, lchar;
  logic [3:0]  left;
  logic [2:0]  lcnt;
  logic [1:0]  nfull, ph1, ph2, pads;
  logic        lflag;
  logic [2:0]  ksum;
  logic [11:0] acc12;

  // Decode side.
  b64c_pkg::dig_t dig;
  logic [12:0] acc13;
  logic [3:0]  dcnt;
  logic [2:0]  dsh, dcnt_n;

  always_comb begin
    acc12 = {st_i.bit_buffer[3:0], item_i.data_byte};
    c1    = acc12[5:0];
    unique case (st_i.bit_count)
      3'd0: begin
        c0 = item_i.data_byte[7:2];
        left = {2'b00, item_i.data_byte[1:0]};
        lcnt = 3'd2;
        nfull = 2'd1;
      end
      3'd2: begin
        c0 = acc12[9:4];
        left = acc12[3:0];
        lcnt = 3'd4;
        nfull = 2'd1;
      end
      default: begin
        c0 = acc12[11:6];
        left = 4'd0;
        lcnt = 3'd0;
        nfull = 2'd2;
      end
    endcase
    lflag = (lcnt != 3'd0);
    lchar = (lcnt == 3'd2) ? {left[1:0], 4'b0000} : {left, 2'b00};
    ph1   = st_i.char_phase + nfull;
    ph2   = ph1 + {1'b0, lflag};
    pads  = 2'd0 - ph2;
    ksum  = {1'b0, nfull} + {2'b00, lflag} + {1'b0, pads};

    dig   = b64c_pkg::dec_char(item_i.data_byte[6:0]);
    acc13 = {st_i.bit_buffer, dig.value};
    dcnt  = {1'b0, st_i.bit_count} + 4'd6;
    dsh   = 3'(dcnt - 4'd8);
    dcnt_n = (dcnt >= 4'd8) ? dsh : dcnt[2:0];

    for (int i = 0; i < b64c_pkg::MaxRes; i++) begin
      res_o[i] = '{out_byte: b64c_pkg::PadChar, is_error: 1'b0};
    end
    cnt_o = '0;
    st_o  = st_i;

    if (mode_i == b64c_pkg::ModeEncode) begin
      res_o[0].out_byte = b64c_pkg::enc_char(c0);
      if (nfull == 2'd2) begin
        res_o[1].out_byte = b64c_pkg::enc_char(c1);
      end else if (lflag) begin
        res_o[1].out_byte = b64c_pkg::enc_char(lchar);
      end
      if (item_i.end_of_message) begin
        cnt_o = (ksum > 3'(b64c_pkg::MaxRes)) ? b64c_pkg::ResCntW'(b64c_pkg::MaxRes)
                                                : b64c_pkg::ResCntW'(ksum);
        st_o  = '0;
      end else begin
        cnt_o = b64c_pkg::ResCntW'(nfull);
        st_o.bit_buffer = {3'b000, left};
        st_o.bit_count  = lcnt;
        st_o.char_phase = ph1;
      end
    end else begin
      if (!st_i.error_seen) begin
        unique case (dig.kind)
          b64c_pkg::DigBad: begin
            res_o[0] = '{out_byte: 8'h00, is_error: 1'b1};
            cnt_o = b64c_pkg::ResCntW'(1);
            st_o.error_seen = 1'b1;
          end
          b64c_pkg::DigValue: begin
            if (dcnt >= 4'd8) begin
              res_o[0] = '{out_byte: 8'(acc13 >> dsh), is_error: 1'b0};
              cnt_o = b64c_pkg::ResCntW'(1);
            end
            st_o.bit_buffer = acc13[6:0] & ((7'd1 << dcnt_n) - 7'd1);
            st_o.bit_count  = dcnt_n;
          end
          default: begin
          end
        endcase
      end
      if (item_i.end_of_message) begin
        st_o = '0;
      end
    end
  end

endmodule

// File: design/base64_codec_top.sv
// Streaming Base64 codec (standard alphabet) with a one-bit mode register.
// An accepted word passes through the input register and then the result
// buffer, from which its results, 0 to 4 of them, are read out. The input
// register holds one further word while the buffer still reads out the
// previous word's results. Reset clears mode and stream state and empties
// both buffers; there is no clearing pass.
module base64_codec_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  b64c_in_if.sink          in_i,
  b64c_out_if.source       out_o,
  b64c_cfg_if.sink         cfg_i
);

  // Mode register and the state carried from word to word within a message.
  logic          mode_q;
  b64c_pkg::st_t st_q, st_d;

  // Input register: holds one accepted word until the result buffer frees up.
  logic            in_vld_q;
  b64c_pkg::item_t in_q;

  // Result buffer: up to four results of one word, read out one per cycle while the output is ready.
  b64c_pkg::res_t [b64c_pkg::MaxRes-1:0] res_q, res_d;
  logic [b64c_pkg::ResCntW-1:0]          rem_q, cnt_d;
  logic [b64c_pkg::ResIdxW-1:0]          rd_q;

  logic in_fire, out_fire, cfg_fire, buf_free, mv;

  assign out_fire = out_o.valid && out_o.ready;
  assign in_fire  = in_i.valid && in_i.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;

  // The buffer can take the next word's results when it is empty or its
  // last result leaves in this cycle, so a word moves on without a gap.
  assign buf_free = (rem_q == '0) || ((rem_q == b64c_pkg::ResCntW'(1)) && out_fire);
  assign mv       = in_vld_q && buf_free;

  // The input register empties whenever its word moves on, so the next word
  // can be taken in the same cycle.
  assign in_i.ready  = !in_vld_q || mv;
  assign cfg_i.ready = 1'b1;

  b64c_step u_step (
    .mode_i (mode_q),
    .item_i (in_q),
    .st_i   (st_q),
    .res_o  (res_d),
    .cnt_o  (cnt_d),
    .st_o   (st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= b64c_pkg::ModeEncode;
      st_q     <= '0;
      in_vld_q <= 1'b0;
      rem_q    <= '0;
      rd_q     <= '0;
    end else begin
      // A mode write aborts any message: the stream state starts over.
      if (cfg_fire) begin
        mode_q <= cfg_i.mode;
        st_q   <= '0;
      end else if (mv) begin
        st_q <= st_d;
      end

      if (in_fire) begin
        in_vld_q <= 1'b1;
      end else if (mv) begin
        in_vld_q <= 1'b0;
      end

      if (mv) begin
        rem_q <= cnt_d;
        rd_q  <= '0;
      end else if (out_fire) begin
        rem_q <= rem_q - b64c_pkg::ResCntW'(1);
        rd_q  <= rd_q + b64c_pkg::ResIdxW'(1);
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= '{data_byte: in_i.data_byte, end_of_message: in_i.end_of_message};
    end
    if (mv) begin
      res_q <= res_d;
    end
  end

  // The last buffered result of a word carries the run_last flag.
  assign out_o.valid    = (rem_q != '0);
  assign out_o.out_byte = res_q[rd_q].out_byte;
  assign out_o.is_error = res_q[rd_q].is_error;
  assign out_o.run_last = (rem_q == b64c_pkg::ResCntW'(1));

  // A word moves into the result buffer only when nothing would be lost.
  a_move_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv |-> (rem_q == '0) || ((rem_q == b64c_pkg::ResCntW'(1)) && out_fire))
    else $error("word moved into an occupied result buffer");

  // The end of a message leaves the stream state clear.
  a_eom_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mv && in_q.end_of_message) |=> (st_q == '0))
    else $error("stream state not cleared after end of message");

  // In encode mode the leftover bit count is always 0, 2 or 4.
  a_enc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == b64c_pkg::ModeEncode) |->
      (st_q.bit_count == 3'd0 || st_q.bit_count == 3'd2 || st_q.bit_count == 3'd4))
    else $error("encode bit count out of step");

  // The buffer never claims more results than it holds.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (rem_q <= b64c_pkg::ResCntW'(b64c_pkg::MaxRes)) &&
                    ({1'b0, rd_q} + rem_q <= b64c_pkg::ResCntW'(b64c_pkg::MaxRes)))
    else $error("result buffer count out of range");

endmodule
